[hdl/dcg_pkg.sv]
`timescale 1ns / 1ps
package dcg_pkg;

  // Fixed point format of coordinates: fraction bits.
  localparam int FRAC_BITS = 16;

  // Defaults of the top level parameters.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int DIST_WIDTH_DEF  = 16;

  // Register and channel widths.
  localparam int MAX_W     = 16;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int COLOR_W   = CHAN_W * NUM_CHAN;
  localparam int NUM_W     = MAX_W + CHAN_W;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POI_X      = 3'd0,
    REG_POI_Y      = 3'd1,
    REG_POI_Z      = 3'd2,
    REG_MAX_DIST   = 3'd3,
    REG_HOT_COLOR  = 3'd4,
    REG_COLD_COLOR = 3'd5
  } cfg_reg_e;

  localparam logic [MAX_W-1:0]   MAX_DIST_RST = 16'd100;
  localparam logic [COLOR_W-1:0] HOT_RST      = 32'hFFFF_FFFF;
  localparam logic [COLOR_W-1:0] COLD_RST     = 32'h0000_0000;

endpackage

[hdl/dcg_isqrt.sv]
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage. Each stage keeps
// the partial root and its square so that the trial needs adds only.
module dcg_isqrt #(
  parameter int DIST_WIDTH = dcg_pkg::DIST_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [2*DIST_WIDTH-1:0] rad_i,
  input  logic                    sat_i,
  output logic                    valid_o,
  output logic [DIST_WIDTH-1:0]   root_o
);

  localparam int DW = DIST_WIDTH;
  localparam int SW = 2 * DW;

  logic          vld_q  [DW];
  logic          sat_q  [DW];
  logic [DW-1:0] root_q [DW];
  logic [SW-1:0] sq_q   [DW];
  logic [SW-1:0] rad_q  [DW];

  for (genvar j = 0; j < DW; j++) begin : g_stage
    localparam int B = DW - 1 - j;
    logic          vld_in;
    logic          sat_in;
    logic [DW-1:0] root_in;
    logic [SW-1:0] sq_in;
    logic [SW-1:0] rad_in;
    logic [SW:0]   trial;

    if (j == 0) begin : g_first
      assign vld_in  = valid_i;
      assign sat_in  = sat_i;
      assign root_in = '0;
      assign sq_in   = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign vld_in  = vld_q[j-1];
      assign sat_in  = sat_q[j-1];
      assign root_in = root_q[j-1];
      assign sq_in   = sq_q[j-1];
      assign rad_in  = rad_q[j-1];
    end

    // (r + 2^B)^2 = r^2 + r * 2^(B+1) + 2^(2B)
    assign trial = (SW+1)'(sq_in) + ((SW+1)'(root_in) << (B + 1))
                 + ((SW+1)'(1) << (2 * B));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sat_q[j] <= sat_in;
        rad_q[j] <= rad_in;
        if (trial <= (SW+1)'(rad_in)) begin
          root_q[j] <= root_in | (DW'(1) << B);
          sq_q[j]   <= trial[SW-1:0];
        end else begin
          root_q[j] <= root_in;
          sq_q[j]   <= sq_in;
        end
      end
    end
  end

  assign valid_o = vld_q[DW-1];
  assign root_o  = sat_q[DW-1] ? '1 : root_q[DW-1];

endmodule

[hdl/dcg_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider for the four color channels, one quotient bit
// per stage. The quotient is known to fit in one channel.
module dcg_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [dcg_pkg::NUM_W-1:0]  num_i  [dcg_pkg::NUM_CHAN],
  input  logic [dcg_pkg::MAX_W-1:0]  div_i,
  output logic                       valid_o,
  output logic [dcg_pkg::CHAN_W-1:0] quot_o [dcg_pkg::NUM_CHAN]
);

  localparam int NW = dcg_pkg::NUM_W;
  localparam int CW = dcg_pkg::CHAN_W;
  localparam int NC = dcg_pkg::NUM_CHAN;
  localparam int XW = NW + CW;

  logic          vld_q [CW];
  logic [NW-1:0] rem_q [CW][NC];
  logic [CW-1:0] quo_q [CW][NC];

  for (genvar k = 0; k < CW; k++) begin : g_stage
    localparam int B = CW - 1 - k;
    logic          vld_in;
    logic [NW-1:0] rem_in [NC];
    logic [CW-1:0] quo_in [NC];
    logic [XW-1:0] dsh;

    assign dsh = XW'(div_i) << B;

    if (k == 0) begin : g_first
      assign vld_in = valid_i;
      for (genvar c = 0; c < NC; c++) begin : g_ch
        assign rem_in[c] = num_i[c];
        assign quo_in[c] = '0;
      end
    end else begin : g_next
      assign vld_in = vld_q[k-1];
      for (genvar c = 0; c < NC; c++) begin : g_ch
        assign rem_in[c] = rem_q[k-1][c];
        assign quo_in[c] = quo_q[k-1][c];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    for (genvar c = 0; c < NC; c++) begin : g_lane
      logic [XW-1:0] diff;
      assign diff = XW'(rem_in[c]) - dsh;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          if (XW'(rem_in[c]) >= dsh) begin
            rem_q[k][c] <= diff[NW-1:0];
            quo_q[k][c] <= quo_in[c] | (CW'(1) << B);
          end else begin
            rem_q[k][c] <= rem_in[c];
            quo_q[k][c] <= quo_in[c];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[CW-1];
  for (genvar c = 0; c < NC; c++) begin : g_out
    assign quot_o[c] = quo_q[CW-1][c];
  end

endmodule

[hdl/distance_color_gradient_unit.sv]
`timescale 1ns / 1ps
// Channel    | Direction | Handshake                     | Payload
// s_axis     | in        | s_axis_tvalid / s_axis_tready | pos_x, pos_y, pos_z
// m_axis     | out       | m_axis_tvalid / m_axis_tready | red, green, blue, alpha
// cfg        | in        | cfg_we_i (no back-pressure)   | cfg_idx_i, cfg_data_i
//
// One transfer is accepted every cycle unless the output stalls. A transfer
// passes the difference, product and sum stages, the square root stages (one bit
// each), the blend stage, the eight divider stages (one quotient bit each) and the
// output register. Reset clears all valid bits and loads the register defaults.
// A stall at the output freezes every stage at once, so nothing is lost or
// repeated; s_axis_tready is low only while a result waits untaken.
module distance_color_gradient_unit #(
  parameter int COORD_WIDTH = dcg_pkg::COORD_WIDTH_DEF,
  parameter int DIST_WIDTH  = dcg_pkg::DIST_WIDTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, pos_z from the lowest bit up, zero padded to bytes
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,

  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red, green, blue, alpha from the lowest bit up
  output logic [dcg_pkg::COLOR_W-1:0]         m_axis_tdata,

  input  logic                                      cfg_we_i,
  input  logic [dcg_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  logic [(COORD_WIDTH > 32 ? COORD_WIDTH : 32)-1:0] cfg_data_i
);

  localparam int C    = COORD_WIDTH;
  localparam int DW   = DIST_WIDTH;
  localparam int F    = dcg_pkg::FRAC_BITS;
  localparam int MW   = dcg_pkg::MAX_W;
  localparam int CW   = dcg_pkg::CHAN_W;
  localparam int NC   = dcg_pkg::NUM_CHAN;
  localparam int NW   = dcg_pkg::NUM_W;
  localparam int DFW  = C + 1;               // magnitude of a coordinate difference
  localparam int AW   = F + DW;              // magnitude that cannot saturate the root
  localparam int EW   = (DFW > AW) ? DFW : AW;
  localparam int H    = (AW + 1) / 2;        // split of the square into partial products
  localparam int L    = AW - H;
  localparam int SQW  = 2 * AW;
  localparam int SUMW = SQW + 2;
  localparam int BW   = (DW > MW) ? DW : MW;

  // Configuration registers.
  logic [C-1:0]  poi_q [3];
  logic [MW-1:0] max_q;
  logic [dcg_pkg::COLOR_W-1:0] hot_q;
  logic [dcg_pkg::COLOR_W-1:0] cold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poi_q[0] <= '0;
      poi_q[1] <= '0;
      poi_q[2] <= '0;
      max_q    <= dcg_pkg::MAX_DIST_RST;
      hot_q    <= dcg_pkg::HOT_RST;
      cold_q   <= dcg_pkg::COLD_RST;
    end else if (cfg_we_i) begin
      unique case (dcg_pkg::cfg_reg_e'(cfg_idx_i))
        dcg_pkg::REG_POI_X:      poi_q[0] <= cfg_data_i[C-1:0];
        dcg_pkg::REG_POI_Y:      poi_q[1] <= cfg_data_i[C-1:0];
        dcg_pkg::REG_POI_Z:      poi_q[2] <= cfg_data_i[C-1:0];
        dcg_pkg::REG_MAX_DIST:   max_q    <= cfg_data_i[MW-1:0];
        dcg_pkg::REG_HOT_COLOR:  hot_q    <= cfg_data_i[dcg_pkg::COLOR_W-1:0];
        dcg_pkg::REG_COLD_COLOR: cold_q   <= cfg_data_i[dcg_pkg::COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // The whole pipeline moves together whenever the output register can take a value.
  logic en;
  logic out_vld_q;
  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 1: absolute differences per axis, with an early flag for
  // differences large enough to saturate the distance.
  logic [AW-1:0] a_q [3];
  logic          sat1_q, vld1_q;
  logic [2:0]    sat_ax;

  for (genvar i = 0; i < 3; i++) begin : g_axis
    logic signed [C:0] dif;
    logic [DFW-1:0]    mag;
    logic [EW-1:0]     mag_e;
    assign dif   = $signed({s_axis_tdata[i*C+C-1], s_axis_tdata[i*C +: C]})
                 - $signed({poi_q[i][C-1], poi_q[i]});
    assign mag   = dif[C] ? DFW'(-dif) : DFW'(dif);
    assign mag_e = EW'(mag);
    assign sat_ax[i] = (mag_e >> AW) != '0;

    always_ff @(posedge clk_i) begin
      if (en) begin
        a_q[i] <= mag_e[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat1_q <= |sat_ax;
    end
  end

  // Stage 2: partial products of each square.
  logic [2*L-1:0] p11_q [3];
  logic [L+H-1:0] p10_q [3];
  logic [2*H-1:0] p00_q [3];
  logic           sat2_q, vld2_q;

  for (genvar i = 0; i < 3; i++) begin : g_pp
    always_ff @(posedge clk_i) begin
      if (en) begin
        p11_q[i] <= (2*L)'(a_q[i][AW-1:H]) * (2*L)'(a_q[i][AW-1:H]);
        p10_q[i] <= (L+H)'(a_q[i][AW-1:H]) * (L+H)'(a_q[i][H-1:0]);
        p00_q[i] <= (2*H)'(a_q[i][H-1:0]) * (2*H)'(a_q[i][H-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sat2_q <= sat1_q;
    end
  end

  // Stage 3: sum of squares, scaled down to whole units squared.
  logic [SUMW-1:0] sum;
  logic [SQW-1:0]  sq [3];
  logic [2*DW-1:0] rad_q;
  logic            sat3_q, vld3_q;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    assign sq[i] = (SQW'(p11_q[i]) << (2 * H)) + (SQW'(p10_q[i]) << (H + 1))
                 + SQW'(p00_q[i]);
  end
  assign sum = SUMW'(sq[0]) + SUMW'(sq[1]) + SUMW'(sq[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q  <= sum[2*F+2*DW-1:2*F];
      sat3_q <= sat2_q || (sum[SUMW-1:2*F+2*DW] != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= s_axis_tvalid;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // Square root: one bit per stage.
  logic          rt_vld;
  logic [DW-1:0] rt_dist;

  dcg_isqrt #(
    .DIST_WIDTH(DW)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vld3_q),
    .rad_i  (rad_q),
    .sat_i  (sat3_q),
    .valid_o(rt_vld),
    .root_o (rt_dist)
  );

  // Blend stage: clamp the distance and form the weighted channel sums.
  logic [MW-1:0] dcl;
  logic [NW-1:0] num_q [NC];
  logic          vb_q;

  assign dcl = (BW'(rt_dist) > BW'(max_q)) ? max_q : MW'(rt_dist);

  for (genvar c = 0; c < NC; c++) begin : g_blend
    logic [NW:0] wsum;
    assign wsum = (NW+1)'(NW'(max_q - dcl) * NW'(hot_q[c*CW +: CW]))
                + (NW+1)'(NW'(dcl) * NW'(cold_q[c*CW +: CW]));
    always_ff @(posedge clk_i) begin
      if (en) begin
        num_q[c] <= wsum[NW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= rt_vld;
    end
  end

  // Division by the maximum distance.
  logic          dv_vld;
  logic [CW-1:0] quot [NC];

  dcg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(vb_q),
    .num_i  (num_q),
    .div_i  (max_q),
    .valid_o(dv_vld),
    .quot_o (quot)
  );

  // Output register. A zero maximum distance passes the hot color through.
  logic [dcg_pkg::COLOR_W-1:0] out_q;
  logic [dcg_pkg::COLOR_W-1:0] out_d;

  for (genvar c = 0; c < NC; c++) begin : g_out
    assign out_d[c*CW +: CW] = (max_q == '0) ? hot_q[c*CW +: CW] : quot[c];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // A result appears only when the divider delivered one on an advancing edge.
  a_rise_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(dv_vld) && $past(en))
    else $error("result appeared without a divider result");

  // An empty divider output leaves an empty output register empty.
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !dv_vld && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result invented from an empty pipeline");

  // A frozen pipeline keeps the blend and divider valid bits unchanged.
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dv_vld) && $stable(vb_q))
    else $error("pipeline moved during a stall");

endmodule

[verif/tb_distance_color_gradient_unit.sv]
`timescale 1ns / 1ps
module tb_distance_color_gradient_unit;

  localparam int CW = dcg_pkg::COORD_WIDTH_DEF;
  localparam int DW = dcg_pkg::DIST_WIDTH_DEF;
  localparam int IN_W = ((3 * CW + 7) / 8) * 8;
  localparam int CFG_W = (CW > 32) ? CW : 32;
  // Pipeline depth of the block, from the input stages to the output register.
  localparam int LATENCY = DW + 13;

  typedef struct packed {
    logic signed [CW-1:0] pos_z;
    logic signed [CW-1:0] pos_y;
    logic signed [CW-1:0] pos_x;
  } particle_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgba_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [dcg_pkg::COLOR_W-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [dcg_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  distance_color_gradient_unit dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  // Shadow copy of the configuration registers, kept in step with every write.
  logic signed [CW-1:0] poi_x_q, poi_y_q, poi_z_q;
  logic [dcg_pkg::MAX_W-1:0] max_dist_q;
  logic [dcg_pkg::COLOR_W-1:0] hot_q, cold_q;

  particle_t pending_particles[$];
  rgba_t expected_colors[$];
  int error_count = 0;
  int sent_count = 0;
  int color_count = 0;
  int clamped_count = 0;
  bit feeding_done = 1'b0;

  // Floor of the true distance, saturated to the distance width.
  function automatic logic [DW-1:0] whole_distance(particle_t p);
    logic [127:0] sum_sq;
    logic [127:0] scaled;
    logic [63:0] diff;
    logic [DW-1:0] root;
    logic [DW-1:0] trial;
    sum_sq = '0;
    diff = 64'($signed(p.pos_x) - $signed(poi_x_q));
    if (diff[63]) diff = -diff;
    sum_sq += 128'(diff) * 128'(diff);
    diff = 64'($signed(p.pos_y) - $signed(poi_y_q));
    if (diff[63]) diff = -diff;
    sum_sq += 128'(diff) * 128'(diff);
    diff = 64'($signed(p.pos_z) - $signed(poi_z_q));
    if (diff[63]) diff = -diff;
    sum_sq += 128'(diff) * 128'(diff);
    scaled = sum_sq >> (2 * dcg_pkg::FRAC_BITS);
    root = '0;
    for (int b = DW - 1; b >= 0; b--) begin
      trial = root | (DW'(1) << b);
      if (128'(trial) * 128'(trial) <= scaled) root = trial;
    end
    return root;
  endfunction

  function automatic rgba_t blend_color(particle_t p);
    logic [31:0] whole_dist;
    logic [31:0] lim;
    logic [63:0] mix;
    logic [7:0] chan [4];
    rgba_t c;
    whole_dist = 32'(whole_distance(p));
    lim = 32'(max_dist_q);
    if (whole_dist > lim) whole_dist = lim;
    for (int k = 0; k < 4; k++) begin
      if (lim == 0) begin
        chan[k] = hot_q[8*k +: 8];
      end else begin
        mix = 64'(lim - whole_dist) * 64'(hot_q[8*k +: 8])
            + 64'(whole_dist) * 64'(cold_q[8*k +: 8]);
        chan[k] = 8'(mix / 64'(lim));
      end
    end
    c.red = chan[0];
    c.green = chan[1];
    c.blue = chan[2];
    c.alpha = chan[3];
    return c;
  endfunction

  // Driver: one transfer per pending particle with a random gap before each.
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_colors.push_back(blend_color(particle_t'(s_axis_tdata[3*CW-1:0])));
        if (blend_color(particle_t'(s_axis_tdata[3*CW-1:0])) == rgba_t'(cold_q))
          clamped_count++;
        sent_count++;
        src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap == 0 && pending_particles.size() > 0) begin
          s_axis_tdata <= IN_W'(pending_particles.pop_front());
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end
      end
    end
  end

  // Monitor: compares each result transfer with the oldest expected color,
  // and randomly stalls the result side.
  int sink_gap = 0;
  always @(posedge clk_i) begin
    rgba_t got;
    rgba_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = rgba_t'(m_axis_tdata);
        color_count++;
        if (expected_colors.size() == 0) begin
          $error("unexpected color transfer %h", got);
          error_count++;
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0d, actual %0d", want.red, got.red);
            error_count++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0d, actual %0d", want.green, got.green);
            error_count++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0d, actual %0d", want.blue, got.blue);
            error_count++;
          end
          if (got.alpha !== want.alpha) begin
            $error("alpha: expected %0d, actual %0d", want.alpha, got.alpha);
            error_count++;
          end
        end
        sink_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
      end
      if (sink_gap > 0) begin
        m_axis_tready <= 1'b0;
        sink_gap--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(dcg_pkg::cfg_reg_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      dcg_pkg::REG_POI_X: poi_x_q = val[CW-1:0];
      dcg_pkg::REG_POI_Y: poi_y_q = val[CW-1:0];
      dcg_pkg::REG_POI_Z: poi_z_q = val[CW-1:0];
      dcg_pkg::REG_MAX_DIST: max_dist_q = val[dcg_pkg::MAX_W-1:0];
      dcg_pkg::REG_HOT_COLOR: hot_q = val[dcg_pkg::COLOR_W-1:0];
      dcg_pkg::REG_COLD_COLOR: cold_q = val[dcg_pkg::COLOR_W-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued particle has gone out and every color came back.
  task automatic drain();
    while (pending_particles.size() > 0 || s_axis_tvalid || expected_colors.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      // Within 200 units of the x coordinate of the point of interest.
      1: return poi_x_q + CW'($signed($urandom_range(0, 2 * 65536 * 200)) - 65536 * 200);
      2: return CW'($signed($urandom_range(0, 2 * 65536 * 60)) - 65536 * 60);
      default: return CW'($signed($urandom_range(0, 2 * 65536 * 4000)) - 65536 * 4000);
    endcase
  endfunction

  task automatic queue_random(int n);
    particle_t p;
    for (int i = 0; i < n; i++) begin
      p.pos_x = rand_coord();
      p.pos_y = rand_coord();
      p.pos_z = rand_coord();
      pending_particles.push_back(p);
    end
  endtask

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  initial begin
    particle_t p;
    poi_x_q = '0;
    poi_y_q = '0;
    poi_z_q = '0;
    max_dist_q = dcg_pkg::MAX_DIST_RST;
    hot_q = dcg_pkg::HOT_RST;
    cold_q = dcg_pkg::COLD_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under reset defaults: origin, whole steps, extremes.
    pending_particles.push_back('{pos_x: 0, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: 32'sh0001_0000, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: 32'sh0000_FFFF, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: 0, pos_y: 32'sh0003_0000, pos_z: 32'sh0004_0000});
    pending_particles.push_back('{pos_x: 32'sh0063_0000, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: 32'sh0064_0000, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: 32'sh0065_0000, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: CMAX, pos_y: CMAX, pos_z: CMAX});
    pending_particles.push_back('{pos_x: CMIN, pos_y: CMIN, pos_z: CMIN});
    pending_particles.push_back('{pos_x: -1, pos_y: -1, pos_z: -1});
    drain();

    // Point of interest at the negative corner: widest differences, so the
    // whole distance can saturate before the clamp.
    write_reg(dcg_pkg::REG_POI_X, CFG_W'(CMIN));
    write_reg(dcg_pkg::REG_POI_Y, CFG_W'(CMIN));
    write_reg(dcg_pkg::REG_POI_Z, CFG_W'(CMIN));
    write_reg(dcg_pkg::REG_MAX_DIST, 16'hFFFF);
    write_reg(dcg_pkg::REG_HOT_COLOR, 32'h0000_0000);
    write_reg(dcg_pkg::REG_COLD_COLOR, 32'hFFFF_FFFF);
    pending_particles.push_back('{pos_x: CMAX, pos_y: CMAX, pos_z: CMAX});
    pending_particles.push_back('{pos_x: CMIN, pos_y: CMIN, pos_z: CMIN});
    pending_particles.push_back('{pos_x: 0, pos_y: CMIN, pos_z: CMIN});
    pending_particles.push_back('{pos_x: CMAX, pos_y: CMIN, pos_z: CMIN});
    drain();

    // Zero max distance returns the hot color unchanged.
    write_reg(dcg_pkg::REG_MAX_DIST, 16'd0);
    write_reg(dcg_pkg::REG_HOT_COLOR, 32'h12_34_56_78);
    pending_particles.push_back('{pos_x: 0, pos_y: 0, pos_z: 0});
    pending_particles.push_back('{pos_x: CMAX, pos_y: 0, pos_z: 0});
    queue_random(4);
    drain();

    // Random phases, each under a fresh configuration; max distance one and
    // mixed colors are among them.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(dcg_pkg::REG_POI_X, ph == 0 ? CFG_W'(CMAX) : CFG_W'($urandom));
      write_reg(dcg_pkg::REG_POI_Y,
                CFG_W'($signed($urandom_range(0, 65536 * 200)) - 65536 * 100));
      write_reg(dcg_pkg::REG_POI_Z, CFG_W'($urandom));
      write_reg(dcg_pkg::REG_MAX_DIST, ph == 1 ? 16'd1 : ph == 2 ? 16'hFFFF :
                ph == 3 ? 16'd0 : 16'($urandom_range(1, 300)));
      write_reg(dcg_pkg::REG_HOT_COLOR, CFG_W'($urandom));
      write_reg(dcg_pkg::REG_COLD_COLOR, CFG_W'($urandom));
      queue_random(128);
      drain();
    end

    $display("Sent %0d particles, checked %0d colors (%0d at the cold end) over 11 settings.",
             sent_count, color_count, clamped_count);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/dcg_pkg.sv
hdl/dcg_isqrt.sv
hdl/dcg_div.sv
hdl/distance_color_gradient_unit.sv
verif/tb_distance_color_gradient_unit.sv
